// ===== rtl/bmt_pkg.sv =====
// Package for the Box-Muller transform unit: widths, fixed-point constants,
// Horner step helpers and shared types. No dependencies.
package bmt_pkg;

  localparam int unsigned UW         = 32;  // uniform word width
  localparam int unsigned FB         = 16;  // fraction bits of sample and registers
  localparam int unsigned LOG_STEPS  = 32;  // squaring steps of the log2 unit
  localparam int unsigned SQRT_STEPS = 32;  // bit pairs of the square root unit
  localparam int unsigned NCOS       = 5;
  localparam int unsigned NSIN       = 4;

  localparam logic [32:0] TWO_LN2    = 33'd5954088944;  // 2 ln 2, Q32
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;  // 2 pi, Q29
  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

  // register indexes
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_STD  = 1'b1;

  // Horner divisors, reciprocal shifts and reciprocals floor(2^(32+sh)/k)
  localparam int unsigned COS_K  [NCOS] = '{90, 56, 30, 12, 2};
  localparam int unsigned COS_SH [NCOS] = '{7, 6, 5, 4, 1};
  localparam logic [32:0] COS_M  [NCOS] = '{
    33'((72'd1 << 39) / 90), 33'((72'd1 << 38) / 56), 33'((72'd1 << 37) / 30),
    33'((72'd1 << 36) / 12), 33'((72'd1 << 33) / 2)};
  localparam int unsigned SIN_K  [NSIN] = '{72, 42, 20, 6};
  localparam int unsigned SIN_SH [NSIN] = '{7, 6, 5, 3};
  localparam logic [32:0] SIN_M  [NSIN] = '{
    33'((72'd1 << 39) / 72), 33'((72'd1 << 38) / 42), 33'((72'd1 << 37) / 20),
    33'((72'd1 << 35) / 6)};

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [31:0] t;
    logic [31:0] x2;
  } ang_meta_t;

  typedef struct packed {
    logic        neg;
    logic [32:0] mag;
  } trig_t;

  // log2 of full scale in Q.32, worked out at elaboration
  function automatic logic [36:0] lg_full();
    logic [63:0] m;
    logic [31:0] f;
    m = 64'({UW{1'b1}});
    f = '0;
    for (int i = 0; i < LOG_STEPS; i++) begin
      m = (m * m) >> 31;
      f = {f[30:0], 1'b0};
      if (m[32]) begin
        m    = m >> 1;
        f[0] = 1'b1;
      end
    end
    return {5'(UW - 1), f};
  endfunction

  localparam logic [36:0] LG_FS = lg_full();

  // (x * y) >> 32 with y in [0, 1.0] Q32
  function automatic logic [31:0] h_mul(logic [31:0] x, logic [32:0] y);
    logic [63:0] p;
    p = 64'(x) * 64'(y[31:0]);
    return y[32] ? x : p[63:32];
  endfunction

  // 1 - v / k, from the reciprocal product; the estimate is low by at most one
  function automatic logic [32:0] h_fix(logic [31:0] v, logic [64:0] pr,
                                        int unsigned sh, int unsigned k);
    logic [31:0] qe;
    logic [39:0] rem;
    qe  = 32'(pr >> (32 + sh));
    rem = 40'(v) - 40'(qe) * 40'(k);
    if (rem >= 40'(k)) qe = qe + 32'd1;
    return ONE_Q32 - 33'(qe);
  endfunction

endpackage

// ===== rtl/gaussian_box_muller_transform_unit.sv =====
// Box-Muller transform unit, cosine branch, fully pipelined.
// Depends on bmt_pkg.
//
// Use: each request on the slave stream carries two uniform words,
// s_axis_tdata = {angle_word, radius_word}. The master stream returns one
// signed Q16.16 sample per request in m_axis_tdata, with m_axis_tuser = 1
// when the scaled sample was clipped to the 32-bit range.
// The pipe has 73 register stages, stage 0 to the output register. One
// request per cycle is sustained unless the receiver stalls. Depth is set
// by the log2 unit (32 squaring stages) and the square root unit (32 bit-pair
// stages) in series; the angle path (Taylor Horner steps, three stages each)
// runs beside them and waits in a delay line.
// mean_offset and std_dev_scale are written through the cfg port; the user
// must do so only while the pipe is empty (not enforced by the block). Reset
// clears all valid bits, sets mean_offset to 0 and std_dev_scale to 1.0. When
// the receiver stalls the whole pipe holds; s_axis_tready drops only while
// the output register is full and not taken, so nothing is lost or repeated.
module gaussian_box_muller_transform_unit
  import bmt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // radius_word[31:0], angle_word[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // normal_sample[31:0]
  output logic        m_axis_tuser    // saturated[0]
);

  localparam int unsigned ANG_STAGE = 3 + 3 * NCOS + 1;            // trig result
  localparam int unsigned RAD_STAGE = 4 + LOG_STEPS + SQRT_STEPS;  // sqrt result
  localparam int unsigned DLY       = RAD_STAGE - ANG_STAGE;
  localparam int unsigned NSTG      = RAD_STAGE + 5;

  logic [NSTG-1:0] vld_q;
  logic            en;

  logic [31:0] mean_q;
  logic [30:0] std_q;

  assign en            = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= 31'(1 << FB);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MEAN: mean_q <= cfg_wdata_i;
        REG_STD:  std_q  <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 0: clamp radius, phase ----------------
  logic [31:0] s0_w1_q, s0_p_q;
  logic [31:0] in_w1, in_w2;

  assign in_w1 = s_axis_tdata[31:0];
  assign in_w2 = s_axis_tdata[63:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_w1_q <= (in_w1 == '0) ? 32'd1 : in_w1;
      // w2 * 2^32 / (2^32 - 1) mod 2^32: w2, except full scale wraps to zero
      s0_p_q  <= (&in_w2) ? 32'd0 : in_w2;
    end
  end

  // ---------------- radius path: normalize ----------------
  logic [4:0]  nrm_e;
  logic [4:0]  n_e_q;
  logic [31:0] n_m_q;

  always_comb begin
    nrm_e = '0;
    for (int b = 0; b < 32; b++) begin
      if (s0_w1_q[b]) nrm_e = 5'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_e_q <= nrm_e;
      n_m_q <= s0_w1_q << (5'd31 - nrm_e);
    end
  end

  // ---------------- log2 fraction: one squaring per stage ----------------
  logic [31:0] lm_q [LOG_STEPS];
  logic [31:0] lf_q [LOG_STEPS];
  logic [4:0]  le_q [LOG_STEPS];
  logic [31:0] lm_in [LOG_STEPS];
  logic [31:0] lf_in [LOG_STEPS];
  logic [4:0]  le_in [LOG_STEPS];

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    logic [63:0] sq;
    if (i == 0) begin : g_first
      assign lm_in[i] = n_m_q;
      assign lf_in[i] = '0;
      assign le_in[i] = n_e_q;
    end else begin : g_next
      assign lm_in[i] = lm_q[i-1];
      assign lf_in[i] = lf_q[i-1];
      assign le_in[i] = le_q[i-1];
    end
    assign sq = 64'(lm_in[i]) * 64'(lm_in[i]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        // m*m >> 31 reaching 2.0 yields a one bit and renormalizes
        lm_q[i] <= sq[63] ? sq[63:32] : sq[62:31];
        lf_q[i] <= {lf_in[i][30:0], sq[63]};
        le_q[i] <= le_in[i];
      end
    end
  end

  // ---------------- -2 ln u1 ----------------
  logic [36:0] lw;
  logic [36:0] d_q;
  logic [63:0] kp0_q;
  logic [37:0] kp1_q;
  logic [31:0] kdl_q;
  logic [71:0] ksum;
  logic [37:0] l_q;

  assign lw   = {le_q[LOG_STEPS-1], lf_q[LOG_STEPS-1]};
  assign ksum = 72'(kp0_q) + (72'(kdl_q) << 32) + (72'(kp1_q) << 32);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q   <= (LG_FS > lw) ? LG_FS - lw : '0;
      // D * 2ln2 split into a 32x32 part and a narrow part
      kp0_q <= 64'(d_q[31:0]) * 64'(TWO_LN2[31:0]);
      kp1_q <= 38'(d_q[36:32]) * 38'(TWO_LN2);
      kdl_q <= d_q[31:0];
      l_q   <= ksum[69:32];
    end
  end

  // ---------------- square root: one bit pair per stage ----------------
  logic [62:0] qn_q [SQRT_STEPS];
  logic [62:0] qr_q [SQRT_STEPS];
  logic [62:0] qn_in [SQRT_STEPS];
  logic [62:0] qr_in [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * j);
    logic [62:0] trial;
    if (j == 0) begin : g_first
      assign qn_in[j] = {1'b0, l_q, 24'b0};
      assign qr_in[j] = '0;
    end else begin : g_next
      assign qn_in[j] = qn_q[j-1];
      assign qr_in[j] = qr_q[j-1];
    end
    assign trial = qr_in[j] + BIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (qn_in[j] >= trial) begin
          qn_q[j] <= qn_in[j] - trial;
          qr_q[j] <= (qr_in[j] >> 1) + BIT;
        end else begin
          qn_q[j] <= qn_in[j];
          qr_q[j] <= qr_in[j] >> 1;
        end
      end
    end
  end

  // ---------------- angle path: octant fold, t, x2 ----------------
  logic [1:0]  a1_quad_q, a2_quad_q;
  logic        a1_swap_q, a2_swap_q;
  logic [29:0] a1_r_q;
  logic [31:0] a2_t_q;
  logic [61:0] tprod;
  logic [63:0] tsq;
  ang_meta_t   meta_q [3*NCOS+1];

  assign tprod = 62'(a1_r_q) * 62'(TWO_PI_Q29);
  assign tsq   = 64'(a2_t_q) * 64'(a2_t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_quad_q <= s0_p_q[31:30];
      a1_swap_q <= s0_p_q[29];
      a1_r_q    <= s0_p_q[29] ? 30'(31'h4000_0000 - {1'b0, s0_p_q[29:0]}) : s0_p_q[29:0];
      a2_quad_q <= a1_quad_q;
      a2_swap_q <= a1_swap_q;
      a2_t_q    <= tprod[60:29];
      meta_q[0] <= '{quad: a2_quad_q, swap: a2_swap_q, t: a2_t_q, x2: tsq[63:32]};
      for (int m = 1; m <= 3 * NCOS; m++) meta_q[m] <= meta_q[m-1];
    end
  end

  // Horner steps: multiply by x2, reciprocal multiply, correct and subtract
  logic [31:0] cv_q [NCOS], cpv_q [NCOS];
  logic [64:0] cp_q [NCOS];
  logic [32:0] cy_q [NCOS], cyi [NCOS];

  for (genvar i = 0; i < NCOS; i++) begin : g_cos
    if (i == 0) begin : g_first
      assign cyi[i] = ONE_Q32;
    end else begin : g_next
      assign cyi[i] = cy_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cv_q[i]  <= h_mul(meta_q[3*i].x2, cyi[i]);
        cp_q[i]  <= 65'(cv_q[i]) * 65'(COS_M[i]);
        cpv_q[i] <= cv_q[i];
        cy_q[i]  <= h_fix(cpv_q[i], cp_q[i], COS_SH[i], COS_K[i]);
      end
    end
  end

  logic [31:0] sv_q [NSIN], spv_q [NSIN];
  logic [64:0] sp_q [NSIN];
  logic [32:0] sy_q [NSIN], syi [NSIN];

  for (genvar i = 0; i < NSIN; i++) begin : g_sin
    if (i == 0) begin : g_first
      assign syi[i] = ONE_Q32;
    end else begin : g_next
      assign syi[i] = sy_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sv_q[i]  <= h_mul(meta_q[3*i].x2, syi[i]);
        sp_q[i]  <= 65'(sv_q[i]) * 65'(SIN_M[i]);
        spv_q[i] <= sv_q[i];
        sy_q[i]  <= h_fix(spv_q[i], sp_q[i], SIN_SH[i], SIN_K[i]);
      end
    end
  end

  // sin = t * poly, then wait for the cosine chain
  logic [31:0] sf_q, sd1_q, sd2_q;
  trig_t       trig_d, trig_q;
  trig_t       cd_q [DLY];
  logic [32:0] cth, sth;
  ang_meta_t   mlast;

  assign mlast = meta_q[3*NCOS];
  assign cth   = mlast.swap ? {1'b0, sd2_q} : cy_q[NCOS-1];
  assign sth   = mlast.swap ? cy_q[NCOS-1] : {1'b0, sd2_q};

  always_comb begin
    case (mlast.quad)
      2'd0:    trig_d = '{neg: 1'b0, mag: cth};
      2'd1:    trig_d = '{neg: 1'b1, mag: sth};
      2'd2:    trig_d = '{neg: 1'b1, mag: cth};
      default: trig_d = '{neg: 1'b0, mag: sth};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q   <= h_mul(meta_q[3*NSIN].t, sy_q[NSIN-1]);
      sd1_q  <= sf_q;
      sd2_q  <= sd1_q;
      trig_q <= trig_d;
      cd_q[0] <= trig_q;
      for (int k = 1; k < DLY; k++) cd_q[k] <= cd_q[k-1];
    end
  end

  // ---------------- combine: R*|c|, deviation, mean, saturate ----------------
  logic [30:0] rad;
  trig_t       tr;
  logic [63:0] zprod;
  logic [35:0] z_q;
  logic        z_neg_q, p_neg_q, f_neg_q;
  logic [62:0] pz0_q;
  logic [34:0] pz1_q;
  logic [35:0] prod_q;
  logic signed [37:0] smp;
  logic [31:0] out_data_q;
  logic        out_sat_q;

  assign rad   = qr_q[SQRT_STEPS-1][30:0];
  assign tr    = cd_q[DLY-1];
  assign zprod = 64'(rad) * 64'(tr.mag[31:0]);
  assign smp   = (f_neg_q ? -$signed({2'b0, prod_q}) : $signed({2'b0, prod_q}))
                 + $signed({{6{mean_q[31]}}, mean_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q     <= tr.mag[32] ? {1'b0, rad, 4'b0} : zprod[63:28];
      z_neg_q <= tr.neg;
      pz0_q   <= 63'(std_q) * 63'(z_q[31:0]);
      pz1_q   <= 35'(std_q) * 35'(z_q[35:32]);
      p_neg_q <= z_neg_q;
      prod_q  <= 36'(pz0_q[62:32]) + 36'(pz1_q);
      f_neg_q <= p_neg_q;
      if (smp > 38'sd2147483647) begin
        out_data_q <= 32'h7FFF_FFFF;
        out_sat_q  <= 1'b1;
      end else if (smp < -38'sd2147483648) begin
        out_data_q <= 32'h8000_0000;
        out_sat_q  <= 1'b1;
      end else begin
        out_data_q <= smp[31:0];
        out_sat_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_sat_q;

  // ---------------- checks ----------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted request did not enter stage 0");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe moved while stalled");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturation flag without clipped sample");

endmodule
